>>> hdl/terrain_lod_triangle_generator_macros.svh
// Assertion macros for the triangle generator; tlod_back includes them.
// Each macro expects clk and rst_n in scope and reports through $error.
`ifndef TERRAIN_LOD_TRIANGLE_GENERATOR_MACROS_SVH
`define TERRAIN_LOD_TRIANGLE_GENERATOR_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define TLOD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlod: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define TLOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlod: next-cycle check failed");

`endif

>>> hdl/tlod_pkg.sv
// Shared types and constants of the terrain triangle generator.
// No dependencies; every module of the generator imports this package.
package tlod_pkg;

  localparam int GRID_VERTS_DEF = 33;
  localparam int LOD_LEVELS_DEF = 6;

  localparam int VW          = 11;  // vertex index width
  localparam int PW          = 4;   // part code width
  localparam int MAX_TRIS    = 4;   // triangles per cell at most
  localparam int OPW         = $clog2(MAX_TRIS);
  localparam int CNTW        = $clog2(MAX_TRIS + 1);
  localparam int QUEUE_DEPTH = 2;

  // Part codes
  localparam logic [PW-1:0] PART_CENTER      = 4'd0;
  localparam logic [PW-1:0] PART_FULL_TOP    = 4'd1;
  localparam logic [PW-1:0] PART_FULL_RIGHT  = 4'd2;
  localparam logic [PW-1:0] PART_FULL_BOTTOM = 4'd3;
  localparam logic [PW-1:0] PART_FULL_LEFT   = 4'd4;
  localparam logic [PW-1:0] PART_LOD_TOP     = 4'd5;
  localparam logic [PW-1:0] PART_LOD_RIGHT   = 4'd6;
  localparam logic [PW-1:0] PART_LOD_BOTTOM  = 4'd7;
  localparam logic [PW-1:0] PART_LOD_LEFT    = 4'd8;

  // Which corner-derived vertex a triangle corner takes
  typedef enum logic [2:0] {
    V_U   = 3'd0,
    V_UL  = 3'd1,
    V_D   = 3'd2,
    V_DL  = 3'd3,
    V_ULL = 3'd4,
    V_DLL = 3'd5,
    V_DD  = 3'd6,
    V_DDL = 3'd7
  } vsel_t;

  typedef struct packed {
    logic [PW-1:0] part;
    vsel_t         va;
    vsel_t         vb;
    vsel_t         vc;
  } tri_op_t;

  // One classified cell: vertex base, step and row stride, plus its triangle list
  typedef struct packed {
    logic [VW-1:0]               base;
    logic [VW-1:0]               step;
    logic [VW-1:0]               stride;
    logic [CNTW-1:0]             cnt;
    tri_op_t [MAX_TRIS-1:0]      ops;
  } tlod_cmd_t;

endpackage

>>> hdl/tlod_front.sv
// Front end: classifies one cell into a vertex frame and a triangle list.
// Uses tlod_pkg; purely combinational, registered by tlod_queue.
module tlod_front
  import tlod_pkg::*;
#(
  parameter int GRID_VERTS = GRID_VERTS_DEF,
  parameter int LOD_LEVELS = LOD_LEVELS_DEF
) (
  input  logic [2:0] lod_level,
  input  logic [4:0] cell_row,
  input  logic [4:0] cell_col,
  output tlod_cmd_t  cmd
);

  localparam int QB = $clog2(GRID_VERTS) + 1;
  localparam int RB = 5 + LOD_LEVELS;
  localparam int IW = ((RB > QB) ? RB : QB) + 1;
  localparam int QW_I = (GRID_VERTS - 1) * GRID_VERTS;

  localparam logic signed [IW-1:0] QV  = IW'(GRID_VERTS - 1);
  localparam logic signed [IW-1:0] ONE = IW'(1);
  localparam logic signed [IW-1:0] TWO = IW'(2);
  localparam logic signed [IW-1:0] ZRO = IW'(0);
  localparam logic [VW-1:0] W11 = VW'(GRID_VERTS);

  function automatic tlod_cmd_t add_op(tlod_cmd_t c, logic [PW-1:0] p,
                                       vsel_t a, vsel_t b, vsel_t d);
    tlod_cmd_t r;
    r = c;
    if (r.cnt < CNTW'(MAX_TRIS)) begin
      r.ops[r.cnt[OPW-1:0]] = '{part: p, va: a, vb: b, vc: d};
      r.cnt = r.cnt + CNTW'(1);
    end
    return r;
  endfunction

  logic signed [IW-1:0] i, j, s, e, n, r2, c2;
  logic [VW-1:0]        i11;
  logic [VW-1:0]        prod;
  logic                 lvl_ok, lvl_last;
  logic                 i0, j0, ie, je, ip, jp;
  logic [PW-1:0]        p;
  logic                 p_ok;

  assign lvl_ok   = (int'(lod_level) < LOD_LEVELS);
  assign lvl_last = (int'(lod_level) == LOD_LEVELS - 1);

  assign i  = signed'(IW'(cell_row)) << lod_level;
  assign j  = signed'(IW'(cell_col)) << lod_level;
  assign s  = ONE << lod_level;
  assign e  = QV - s;
  assign n  = (QV + s - ONE) >>> lod_level;
  assign r2 = signed'(IW'(cell_row)) + TWO;
  assign c2 = signed'(IW'(cell_col)) + TWO;

  // Row offset modulo the index width
  assign i11  = VW'(i);
  assign prod = i11 * W11;

  assign i0 = (i == ZRO);
  assign j0 = (j == ZRO);
  assign ie = (i == e);
  assign je = (j == e);
  assign ip = (i > ZRO);
  assign jp = (j > ZRO);

  // Side or center choice when the cell is not a corner
  always_comb begin
    p    = PART_CENTER;
    p_ok = 1'b1;
    if (i0 && jp)                            p = PART_FULL_TOP;
    else if (ie && jp)                       p = PART_FULL_BOTTOM;
    else if (ip && j0)                       p = PART_FULL_LEFT;
    else if (ip && je)                       p = PART_FULL_RIGHT;
    else if (ip && jp && (i < e) && (j < e)) p = PART_CENTER;
    else                                     p_ok = 1'b0;
  end

  always_comb begin
    cmd        = '0;
    cmd.base   = prod + VW'(j);
    cmd.step   = VW'(s);
    cmd.stride = VW'(W11 << lod_level);
    if (!lvl_ok) begin
      cmd.cnt = '0;
    end else if (lvl_last) begin
      // Whole chunk as one quad
      if (cell_row == 5'd0 && cell_col == 5'd0) begin
        cmd.base   = '0;
        cmd.step   = VW'(GRID_VERTS - 1);
        cmd.stride = VW'(QW_I);
        cmd = add_op(cmd, PART_CENTER, V_U, V_UL, V_D);
        cmd = add_op(cmd, PART_CENTER, V_D, V_UL, V_DL);
      end
    end else if (i < QV && j < QV) begin
      if (i0 && j0) begin
        cmd = add_op(cmd, PART_FULL_TOP,  V_U, V_UL, V_DL);
        cmd = add_op(cmd, PART_FULL_LEFT, V_U, V_DL, V_D);
      end else if (i0 && je) begin
        cmd = add_op(cmd, PART_FULL_TOP,   V_U, V_UL, V_D);
        cmd = add_op(cmd, PART_FULL_RIGHT, V_D, V_UL, V_DL);
      end else if (ie && j0) begin
        cmd = add_op(cmd, PART_FULL_BOTTOM, V_D, V_UL, V_DL);
        cmd = add_op(cmd, PART_FULL_LEFT,   V_U, V_UL, V_D);
      end else if (ie && je) begin
        cmd = add_op(cmd, PART_FULL_BOTTOM, V_U, V_DL, V_D);
        cmd = add_op(cmd, PART_FULL_RIGHT,  V_U, V_UL, V_DL);
      end else if (p_ok) begin
        cmd = add_op(cmd, p, V_U, V_UL, V_D);
        cmd = add_op(cmd, p, V_D, V_UL, V_DL);
      end

      // Stitching: top, bottom, left, right
      if (i0 && c2 <= n) begin
        if (!cell_col[0]) cmd = add_op(cmd, PART_LOD_TOP, V_U, V_ULL, V_DL);
        else              cmd = add_op(cmd, PART_LOD_TOP, V_D, V_UL, V_DLL);
      end
      if (ie && c2 <= n) begin
        if (cell_col[0]) cmd = add_op(cmd, PART_LOD_BOTTOM, V_U, V_ULL, V_DL);
        else             cmd = add_op(cmd, PART_LOD_BOTTOM, V_D, V_UL, V_DLL);
      end
      if (j0 && r2 <= n) begin
        if (!cell_row[0]) cmd = add_op(cmd, PART_LOD_LEFT, V_U, V_DL, V_DD);
        else              cmd = add_op(cmd, PART_LOD_LEFT, V_UL, V_DDL, V_D);
      end
      if (je && r2 <= n) begin
        if (cell_row[0]) cmd = add_op(cmd, PART_LOD_RIGHT, V_U, V_DL, V_DD);
        else             cmd = add_op(cmd, PART_LOD_RIGHT, V_UL, V_DDL, V_D);
      end
    end
  end

endmodule

>>> hdl/tlod_queue.sv
// Short register queue of classified cells between front and back end.
// Uses tlod_pkg for the entry type and depth.
module tlod_queue
  import tlod_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tlod_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output tlod_cmd_t head
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tlod_cmd_t        slot_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;

  assign full       = (fill_r == CW'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) fill_nxt = fill_r + CW'(1);
    else if (pop && !push) fill_nxt = fill_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/tlod_back.sv
// Back end: walks the head cell's triangle list, one triangle a cycle while
// out_stall is low, into the output register. Uses tlod_pkg and the assertion macro header.
`include "terrain_lod_triangle_generator_macros.svh"
module tlod_back
  import tlod_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  tlod_cmd_t     head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [PW-1:0] out_part,
  output logic [VW-1:0] out_vert_a,
  output logic [VW-1:0] out_vert_b,
  output logic [VW-1:0] out_vert_c,
  output logic          out_last_of_cell
);

  logic [OPW-1:0] k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [PW-1:0]  part_r;
  logic [VW-1:0]  va_r, vb_r, vc_r;
  logic           last_r;

  logic           load;
  logic           last;
  tri_op_t        op;
  logic [VW-1:0]  vtab [8];

  assign op   = head.ops[k_r];
  assign last = ({1'b0, k_r} == head.cnt - CNTW'(1));
  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && last;

  // Corner vertices of the cell frame, modulo the index width
  always_comb begin
    vtab[V_U]   = head.base;
    vtab[V_UL]  = head.base + head.step;
    vtab[V_D]   = head.base + head.stride;
    vtab[V_DL]  = vtab[V_D] + head.step;
    vtab[V_ULL] = vtab[V_UL] + head.step;
    vtab[V_DLL] = vtab[V_DL] + head.step;
    vtab[V_DD]  = vtab[V_D] + head.stride;
    vtab[V_DDL] = vtab[V_DD] + head.step;
  end

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      k_nxt         = last ? '0 : k_r + OPW'(1);
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part_r <= op.part;
      va_r   <= vtab[op.va];
      vb_r   <= vtab[op.vb];
      vc_r   <= vtab[op.vc];
      last_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_part         = part_r;
  assign out_vert_a       = va_r;
  assign out_vert_b       = vb_r;
  assign out_vert_c       = vc_r;
  assign out_last_of_cell = last_r;

  `TLOD_ASSERT_NOW(a_head_cnt_range, head_valid,
                   head.cnt != '0 && head.cnt <= CNTW'(MAX_TRIS))
  `TLOD_ASSERT_NOW(a_index_in_list, head_valid, {1'b0, k_r} < head.cnt)
  `TLOD_ASSERT_NEXT(a_cell_continues, load && !last, head_valid && k_r != '0)
  `TLOD_ASSERT_NEXT(a_last_resets_index, pop, k_r == '0 && out_last_of_cell)

endmodule

>>> hdl/terrain_lod_triangle_generator.sv
// Terrain chunk LOD triangle generator, top level.
// Input channel (in_*): one request names a grid cell as level, row and column.
// Result channel (out_*): one request is one triangle: part code, three vertex
// indices into the full 33x33 grid, and a flag on the last triangle of the cell.
// A cell yields zero to four triangles, in fixed order: full-detail triangles
// first, then stitching triangles top, bottom, left, right.
// With the queue empty, a taken cell is written into the queue, and its first
// triangle is then loaded from the queue head into the output register.
// The result channel carries one triangle per cycle while out_stall is low, from
// the single output register; a cell yields up to four triangles, and cells that
// yield nothing are dropped at the input without entering the queue.
// The front end classifies a cell in the cycle it is taken and writes it into
// a two-entry queue; the back end walks the queue head into the output register.
// in_stall is high while the queue is full; it does not depend on in_valid.
// When out_stall is high the output register holds its triangle and the back end
// waits; the queue keeps taking cells until it fills.
// Reset (rst_n low, synchronous) empties the queue and drops any held triangle.
module terrain_lod_triangle_generator
  import tlod_pkg::*;
#(
  parameter int GRID_VERTS = GRID_VERTS_DEF,
  parameter int LOD_LEVELS = LOD_LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_lod_level,
  input  logic [4:0]    in_cell_row,
  input  logic [4:0]    in_cell_col,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [PW-1:0] out_part,
  output logic [VW-1:0] out_vert_a,
  output logic [VW-1:0] out_vert_b,
  output logic [VW-1:0] out_vert_c,
  output logic          out_last_of_cell
);

  tlod_cmd_t front_cmd;
  tlod_cmd_t head;
  logic      q_full;
  logic      head_valid;
  logic      pop;
  logic      push;

  // Classify the incoming cell
  tlod_front #(
    .GRID_VERTS (GRID_VERTS),
    .LOD_LEVELS (LOD_LEVELS)
  ) u_front (
    .lod_level (in_lod_level),
    .cell_row  (in_cell_row),
    .cell_col  (in_cell_col),
    .cmd       (front_cmd)
  );

  // Take a cell whenever the queue has room; drop cells without triangles
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && (front_cmd.cnt != '0);

  tlod_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (front_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Emit the head cell's triangles, one per cycle while out_stall is low
  tlod_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_part         (out_part),
    .out_vert_a       (out_vert_a),
    .out_vert_b       (out_vert_b),
    .out_vert_c       (out_vert_c),
    .out_last_of_cell (out_last_of_cell)
  );

endmodule
